// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the swept box collision block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define SWBC_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swbc check failed");

// Next-cycle implication, sampled on clk, off during rst
`define SWBC_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swbc check failed");

`endif

// ===== rtl/swbc_pkg.sv =====
// Package: widths, stage numbering, edge codes and shared types of the collision pipeline
package swbc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SW        = 32;          // signed coordinate and step width
  localparam int UW        = 31;          // unsigned size and time width
  localparam int TW        = UW;
  localparam int CW        = SW + 3;      // doubled, relative edge positions
  localparam int MW        = CW - 1;      // magnitude of an edge position
  localparam int HALF      = MW / 2;      // split point of the wide products
  localparam int PW        = MW + SW;     // product magnitude width
  localparam int NUMW      = MW + FRAC_BITS;
  localparam int DENW      = SW + 1;
  localparam int REMW      = DENW + TW;

  localparam logic [TW-1:0] TIME_MAX = '1;
  localparam logic [SW-1:0] SAT_POS  = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SAT_NEG  = {1'b1, {(SW-1){1'b0}}};

  // divider: quotient bits per stage and stage count
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = (TW + DIV_BPS - 1) / DIV_BPS;

  // pipeline stage numbers
  localparam int E_ORIENT  = 1;
  localparam int E_PROD    = 2;
  localparam int E_SUM     = 3;
  localparam int E_SIGN    = 4;
  localparam int E_CMP     = 5;
  localparam int EDGE_LAST = E_PROD + DIV_STAGES;
  localparam int PAIR_STG  = EDGE_LAST + 1;
  localparam int OUT_STG   = EDGE_LAST + 2;
  localparam int NSTG      = OUT_STG + 1;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_idx_t;

  typedef logic [NSTG-1:0] stage_en_t;

  // per-beat data that rides alongside the edge units
  typedef struct packed {
    logic [TW-1:0]        limit;
    logic signed [SW-1:0] wp;
    logic signed [SW-1:0] wn;
    logic signed [SW-1:0] hp;
    logic signed [SW-1:0] hn;
  } side_t;

endpackage

// ===== rtl/swbc_if.sv =====
// Interfaces: query and result channels with valid/ready handshake
interface swbc_in_if;
  import swbc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] stationary_center_x;
  logic signed [SW-1:0] stationary_center_y;
  logic [UW-1:0]        stationary_width;
  logic [UW-1:0]        stationary_height;
  logic signed [SW-1:0] moving_center_x;
  logic signed [SW-1:0] moving_center_y;
  logic [UW-1:0]        moving_width;
  logic [UW-1:0]        moving_height;
  logic signed [SW-1:0] step_x;
  logic signed [SW-1:0] step_y;
  logic [UW-1:0]        time_limit;

  modport source (
    output valid, stationary_center_x, stationary_center_y, stationary_width,
           stationary_height, moving_center_x, moving_center_y, moving_width,
           moving_height, step_x, step_y, time_limit,
    input  ready
  );
  modport sink (
    input  valid, stationary_center_x, stationary_center_y, stationary_width,
           stationary_height, moving_center_x, moving_center_y, moving_width,
           moving_height, step_x, step_y, time_limit,
    output ready
  );
endinterface

interface swbc_out_if;
  import swbc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TW-1:0]        hit_time;
  logic                 hit_found;
  logic [1:0]           hit_edge;
  logic signed [SW-1:0] hit_edge_x;
  logic signed [SW-1:0] hit_edge_y;

  modport source (
    output valid, hit_time, hit_found, hit_edge, hit_edge_x, hit_edge_y,
    input  ready
  );
  modport sink (
    input  valid, hit_time, hit_found, hit_edge, hit_edge_x, hit_edge_y,
    output ready
  );
endinterface

// ===== rtl/swbc_edge.sv =====
// Edge unit: exact edge-parameter test and pipelined ray-time divider for one edge
module swbc_edge (
  input  logic                           clk,
  input  swbc_pkg::stage_en_t            en,
  input  logic signed [swbc_pkg::CW-1:0] k,
  input  logic signed [swbc_pkg::SW-1:0] s,
  input  logic signed [swbc_pkg::CW-1:0] lo,
  input  logic signed [swbc_pkg::CW-1:0] hi,
  input  logic signed [swbc_pkg::SW-1:0] par,
  output logic                           ok,
  output logic [swbc_pkg::TW-1:0]        t
);
  import swbc_pkg::*;

  // orientation stage signals
  logic signed [CW-1:0] k_or, lo_abs, hi_abs;
  logic signed [SW-1:0] s_negv, par_negv;
  logic [SW-1:0]        s_mag, par_mag;
  logic                 fail_or;

  logic [MW-1:0] k1, lo1, hi1;
  logic [SW-1:0] s1, par1;
  logic          lo_neg1, hi_neg1, par_neg1, fail1;

  // partial products
  logic [HALF+SW-1:0]    lo_pl2, hi_pl2, at_pl2;
  logic [MW-HALF+SW-1:0] lo_ph2, hi_ph2, at_ph2;
  logic                  lo_neg2, hi_neg2, par_neg2, fail2;

  // summed magnitudes
  logic [PW-1:0] lo_p3, hi_p3, at_p3;
  logic          lo_neg3, hi_neg3, par_neg3, fail3;

  // signed products
  logic signed [PW:0] lo_s4, hi_s4, at_s4;
  logic               fail4;

  logic ok_d [E_CMP:EDGE_LAST];

  // divider pipeline
  logic [REMW-1:0] drem [DIV_STAGES+1];
  logic [DENW-1:0] dden [DIV_STAGES+1];
  logic [TW-1:0]   dq   [DIV_STAGES+1];
  logic            dsat [DIV_STAGES+1];

  logic [NUMW-1:0] num2;
  logic [DENW-1:0] den2;

  // turn the step positive across the edge, take magnitudes
  always_comb begin
    k_or     = s[SW-1] ? -k : k;
    s_negv   = -s;
    par_negv = -par;
    s_mag    = s[SW-1] ? s_negv : s;
    par_mag  = par[SW-1] ? par_negv : par;
    lo_abs   = lo[CW-1] ? -lo : lo;
    hi_abs   = hi[CW-1] ? -hi : hi;
    fail_or  = (s == '0) || (lo == hi) || k_or[CW-1];
  end

  always_ff @(posedge clk) begin
    if (en[E_ORIENT]) begin
      k1       <= k_or[MW-1:0];
      s1       <= s_mag;
      par1     <= par_mag;
      lo1      <= lo_abs[MW-1:0];
      hi1      <= hi_abs[MW-1:0];
      lo_neg1  <= lo[CW-1];
      hi_neg1  <= hi[CW-1];
      par_neg1 <= par[SW-1];
      fail1    <= fail_or;
    end
  end

  // split products, divider set-up
  always_comb begin
    num2 = {k1, {FRAC_BITS{1'b0}}};
    den2 = {s1, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en[E_PROD]) begin
      lo_pl2   <= lo1[HALF-1:0] * s1;
      lo_ph2   <= lo1[MW-1:HALF] * s1;
      hi_pl2   <= hi1[HALF-1:0] * s1;
      hi_ph2   <= hi1[MW-1:HALF] * s1;
      at_pl2   <= k1[HALF-1:0] * par1;
      at_ph2   <= k1[MW-1:HALF] * par1;
      lo_neg2  <= lo_neg1;
      hi_neg2  <= hi_neg1;
      par_neg2 <= par_neg1;
      fail2    <= fail1;
      drem[0]  <= REMW'(num2);
      dden[0]  <= den2;
      dq[0]    <= '0;
      dsat[0]  <= REMW'(num2) >= {den2, {TW{1'b0}}};
    end
  end

  // combine halves
  always_ff @(posedge clk) begin
    if (en[E_SUM]) begin
      lo_p3    <= PW'(lo_pl2) + (PW'(lo_ph2) << HALF);
      hi_p3    <= PW'(hi_pl2) + (PW'(hi_ph2) << HALF);
      at_p3    <= PW'(at_pl2) + (PW'(at_ph2) << HALF);
      lo_neg3  <= lo_neg2;
      hi_neg3  <= hi_neg2;
      par_neg3 <= par_neg2;
      fail3    <= fail2;
    end
  end

  // apply signs
  always_ff @(posedge clk) begin
    if (en[E_SIGN]) begin
      lo_s4 <= lo_neg3 ? -$signed({1'b0, lo_p3}) : $signed({1'b0, lo_p3});
      hi_s4 <= hi_neg3 ? -$signed({1'b0, hi_p3}) : $signed({1'b0, hi_p3});
      at_s4 <= par_neg3 ? -$signed({1'b0, at_p3}) : $signed({1'b0, at_p3});
      fail4 <= fail3;
    end
  end

  // crossing lies on the edge, ends included
  always_ff @(posedge clk) begin
    if (en[E_CMP]) begin
      ok_d[E_CMP] <= !fail4 && (lo_s4 <= at_s4) && (at_s4 <= hi_s4);
    end
  end

  // hold the edge test until the quotient is ready
  for (genvar e = E_CMP + 1; e <= EDGE_LAST; e++) begin : g_okdly
    always_ff @(posedge clk) begin
      if (en[e]) begin
        ok_d[e] <= ok_d[e-1];
      end
    end
  end

  // restoring division, DIV_BPS quotient bits per stage, MSB first
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [REMW-1:0] r;
    logic [TW-1:0]   q;

    always_comb begin
      int b;
      r = drem[g];
      q = dq[g];
      for (int j = 0; j < DIV_BPS; j++) begin
        b = TW - 1 - (g * DIV_BPS + j);
        if (b >= 0) begin
          if (r >= (REMW'(dden[g]) << b)) begin
            r = r - (REMW'(dden[g]) << b);
            q = q | (TW'(1) << b);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[E_PROD+1+g]) begin
        drem[g+1] <= r;
        dq[g+1]   <= q;
        dden[g+1] <= dden[g];
        dsat[g+1] <= dsat[g];
      end
    end
  end

  assign ok = ok_d[EDGE_LAST];
  assign t  = dsat[DIV_STAGES] ? TIME_MAX : dq[DIV_STAGES];

endmodule

// ===== rtl/swept_box_collision_time.sv =====
// Swept box collision time: top level, box set-up, edge units, earliest-hit selection
//
// Takes one query per clock while the result channel does not stall, and returns
// one result per query, in order. The ray-time dividers resolve four quotient bits
// per stage. Each beat carries both boxes, the step and a time limit; the result
// is the earliest edge hit strictly below the limit (top, right, bottom, left order
// on ties) or the limit itself with hit_found low. Hit times are rounded down and
// saturate at the largest unsigned Q15.16 value; edge vectors saturate to 32-bit
// signed. Stalls on the result side fill the pipeline's bubbles before query.ready
// drops.
module swept_box_collision_time (
  input logic       clk,
  input logic       rst,
  swbc_in_if.sink   query,
  swbc_out_if.source result
);
  import swbc_pkg::*;

  `include "assert_macros.svh"

  logic [NSTG-1:0] v;
  stage_en_t       en;

  // stage 0 signals
  logic [SW-1:0]        w, h;
  logic signed [CW-1:0] cx2, cy2, ox2, oy2, wz, hz;
  side_t                side_in;

  logic signed [CW-1:0] xl0, xr0, yb0, yt0;
  logic signed [SW-1:0] dx0, dy0;
  side_t                side [0:EDGE_LAST];

  logic          eok [4];
  logic [TW-1:0] et  [4];

  // pair stage
  logic          ca0, ca1, cb0, cb1, sela, selb;
  logic          pa_c, pb_c;
  logic [TW-1:0] pa_t, pb_t;
  edge_idx_t     pa_e, pb_e;
  side_t         side_p;

  // final select
  logic                 f_found, selfin;
  logic [TW-1:0]        f_time;
  edge_idx_t            f_edge;
  logic signed [SW-1:0] f_vx, f_vy;

  logic                 o_found;
  logic [TW-1:0]        o_time;
  edge_idx_t            o_edge;
  logic signed [SW-1:0] o_vx, o_vy;

  // terms for the checks
  logic chk_miss, chk_clear, chk_horiz, chk_in_only;

  // per-stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    en[OUT_STG] = !v[OUT_STG] || result.ready;
    for (int i = OUT_STG - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign query.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= query.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // grown box edges relative to the ray origin, all doubled
  always_comb begin
    w   = SW'(query.stationary_width) + SW'(query.moving_width);
    h   = SW'(query.stationary_height) + SW'(query.moving_height);
    cx2 = {{(CW-SW-1){query.stationary_center_x[SW-1]}}, query.stationary_center_x, 1'b0};
    cy2 = {{(CW-SW-1){query.stationary_center_y[SW-1]}}, query.stationary_center_y, 1'b0};
    ox2 = {{(CW-SW-1){query.moving_center_x[SW-1]}}, query.moving_center_x, 1'b0};
    oy2 = {{(CW-SW-1){query.moving_center_y[SW-1]}}, query.moving_center_y, 1'b0};
    wz  = {{(CW-SW){1'b0}}, w};
    hz  = {{(CW-SW){1'b0}}, h};
    side_in.limit = query.time_limit;
    side_in.wp    = w[SW-1] ? SAT_POS : w;
    side_in.wn    = (w > SAT_NEG) ? SAT_NEG : -w;
    side_in.hp    = h[SW-1] ? SAT_POS : h;
    side_in.hn    = (h > SAT_NEG) ? SAT_NEG : -h;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xl0     <= cx2 - wz - ox2;
      xr0     <= cx2 + wz - ox2;
      yb0     <= cy2 - hz - oy2;
      yt0     <= cy2 + hz - oy2;
      dx0     <= query.step_x;
      dy0     <= query.step_y;
      side[0] <= side_in;
    end
  end

  // sideband alongside the edge units
  for (genvar i = 1; i <= EDGE_LAST; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[i]) begin
        side[i] <= side[i-1];
      end
    end
  end

  // edge units for the top, right, bottom and left edges
  swbc_edge u_top (
    .clk(clk), .en(en), .k(yt0), .s(dy0), .lo(xl0), .hi(xr0), .par(dx0),
    .ok(eok[EDGE_TOP]), .t(et[EDGE_TOP])
  );
  swbc_edge u_right (
    .clk(clk), .en(en), .k(xr0), .s(dx0), .lo(yb0), .hi(yt0), .par(dy0),
    .ok(eok[EDGE_RIGHT]), .t(et[EDGE_RIGHT])
  );
  swbc_edge u_bottom (
    .clk(clk), .en(en), .k(yb0), .s(dy0), .lo(xl0), .hi(xr0), .par(dx0),
    .ok(eok[EDGE_BOTTOM]), .t(et[EDGE_BOTTOM])
  );
  swbc_edge u_left (
    .clk(clk), .en(en), .k(xl0), .s(dx0), .lo(yb0), .hi(yt0), .par(dy0),
    .ok(eok[EDGE_LEFT]), .t(et[EDGE_LEFT])
  );

  // candidates below the limit, pairwise earliest; earlier edge keeps ties
  always_comb begin
    ca0  = eok[EDGE_TOP] && (et[EDGE_TOP] < side[EDGE_LAST].limit);
    ca1  = eok[EDGE_RIGHT] && (et[EDGE_RIGHT] < side[EDGE_LAST].limit);
    cb0  = eok[EDGE_BOTTOM] && (et[EDGE_BOTTOM] < side[EDGE_LAST].limit);
    cb1  = eok[EDGE_LEFT] && (et[EDGE_LEFT] < side[EDGE_LAST].limit);
    sela = ca1 && (!ca0 || (et[EDGE_RIGHT] < et[EDGE_TOP]));
    selb = cb1 && (!cb0 || (et[EDGE_LEFT] < et[EDGE_BOTTOM]));
  end

  always_ff @(posedge clk) begin
    if (en[PAIR_STG]) begin
      pa_c   <= ca0 || ca1;
      pa_t   <= sela ? et[EDGE_RIGHT] : et[EDGE_TOP];
      pa_e   <= sela ? EDGE_RIGHT : EDGE_TOP;
      pb_c   <= cb0 || cb1;
      pb_t   <= selb ? et[EDGE_LEFT] : et[EDGE_BOTTOM];
      pb_e   <= selb ? EDGE_LEFT : EDGE_BOTTOM;
      side_p <= side[EDGE_LAST];
    end
  end

  // final pick and edge vector
  always_comb begin
    selfin  = pb_c && (!pa_c || (pb_t < pa_t));
    f_found = pa_c || pb_c;
    f_time  = side_p.limit;
    f_edge  = EDGE_TOP;
    f_vx    = '0;
    f_vy    = '0;
    if (f_found) begin
      f_time = selfin ? pb_t : pa_t;
      f_edge = selfin ? pb_e : pa_e;
      case (f_edge)
        EDGE_TOP:    f_vx = side_p.wn;
        EDGE_RIGHT:  f_vy = side_p.hp;
        EDGE_BOTTOM: f_vx = side_p.wp;
        EDGE_LEFT:   f_vy = side_p.hn;
        default:     f_vx = '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[OUT_STG]) begin
      o_found <= f_found;
      o_time  <= f_time;
      o_edge  <= f_edge;
      o_vx    <= f_vx;
      o_vy    <= f_vy;
    end
  end

  assign result.valid      = v[OUT_STG];
  assign result.hit_time   = o_time;
  assign result.hit_found  = o_found;
  assign result.hit_edge   = o_edge;
  assign result.hit_edge_x = o_vx;
  assign result.hit_edge_y = o_vy;

  // checks
  assign chk_miss    = result.valid && !result.hit_found;
  assign chk_clear   = result.hit_edge == EDGE_TOP && result.hit_edge_x == '0 &&
                       result.hit_edge_y == '0;
  assign chk_horiz   = result.valid && result.hit_found &&
                       (result.hit_edge == EDGE_TOP || result.hit_edge == EDGE_BOTTOM);
  assign chk_in_only = query.valid && query.ready && !(result.valid && result.ready);

  `SWBC_CHECK(a_miss_clear, chk_miss, chk_clear)
  `SWBC_CHECK(a_horiz_edge, chk_horiz, result.hit_edge_y == '0)
  `SWBC_CHECK(a_full_when_blocked, !query.ready, &v)
  `SWBC_NEXT(a_fill_count, chk_in_only, $countones(v) == $past($countones(v)) + 1)

endmodule

// ===== bench/swbc_tb_if.sv =====
// Testbench-side copies of nothing: channel interfaces come from the RTL; this file holds the bench's item types
package swbc_tb_pkg;
  import swbc_pkg::*;

  // one collision query as driven onto the query channel
  typedef struct {
    logic signed [SW-1:0] scx;
    logic signed [SW-1:0] scy;
    logic [UW-1:0]        sw;
    logic [UW-1:0]        sh;
    logic signed [SW-1:0] mcx;
    logic signed [SW-1:0] mcy;
    logic [UW-1:0]        mw;
    logic [UW-1:0]        mh;
    logic signed [SW-1:0] dx;
    logic signed [SW-1:0] dy;
    logic [UW-1:0]        limit;
  } query_t;

  // one expected or observed result beat
  typedef struct {
    logic [TW-1:0]        t;
    logic                 found;
    logic [1:0]           edge_id;
    logic signed [SW-1:0] ex;
    logic signed [SW-1:0] ey;
  } answer_t;
endpackage

// ===== bench/testbench.sv =====
// Top-level testbench: random and directed queries, predictor, scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import swbc_pkg::*;
  import swbc_tb_pkg::*;

  logic clk;
  logic rst;
  swbc_in_if  query ();
  swbc_out_if result ();

  swept_box_collision_time dut (
    .clk(clk), .rst(rst), .query(query.sink), .result(result.source)
  );

  query_t  pending_q[$];
  answer_t awaited_q[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      stim_done;
  bit      hold_off;
  bit      in_fire;
  int      burst_left;
  int      gap_left;
  int      stall_phase;

  localparam int LIMIT_CYCLES = 400000;

  // edge test on doubled positions relative to the ray origin
  function automatic bit edge_hit(input logic signed [63:0] k_in,
                                  input logic signed [63:0] s_in,
                                  input logic signed [63:0] lo,
                                  input logic signed [63:0] hi,
                                  input logic signed [63:0] par,
                                  output logic [TW-1:0] tq);
    logic signed [63:0]  k;
    logic signed [63:0]  s;
    logic signed [127:0] at;
    logic signed [127:0] lo_s;
    logic signed [127:0] hi_s;
    logic [127:0]        q;
    k = k_in;
    s = s_in;
    tq = '0;
    if (s == 0 || lo == hi) return 0;
    if (s < 0) begin
      k = -k;
      s = -s;
    end
    if (k < 0) return 0;
    at   = 128'(k) * 128'(par);
    lo_s = 128'(lo) * 128'(s);
    hi_s = 128'(hi) * 128'(s);
    if (!(lo_s <= at) || !(at <= hi_s)) return 0;
    q = (128'(k) << FRAC_BITS) / (128'(s) * 2);
    tq = (q > 128'(TIME_MAX)) ? TIME_MAX : q[TW-1:0];
    return 1;
  endfunction

  function automatic logic signed [SW-1:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return SAT_POS;
    if (v < -64'sh80000000) return SAT_NEG;
    return v[SW-1:0];
  endfunction

  // earliest edge hit below the limit
  function automatic answer_t predict_hit(input query_t q);
    answer_t a;
    logic signed [63:0] w, h, xl, xr, yb, yt, dx, dy, k, s, lo, hi, par, vx, vy;
    logic [TW-1:0] t;
    bit ok;
    w  = 64'(q.sw) + 64'(q.mw);
    h  = 64'(q.sh) + 64'(q.mh);
    xl = 2 * 64'(q.scx) - w - 2 * 64'(q.mcx);
    xr = 2 * 64'(q.scx) + w - 2 * 64'(q.mcx);
    yb = 2 * 64'(q.scy) - h - 2 * 64'(q.mcy);
    yt = 2 * 64'(q.scy) + h - 2 * 64'(q.mcy);
    dx = 64'(q.dx);
    dy = 64'(q.dy);
    a.t = q.limit;
    a.found = 0;
    a.edge_id = EDGE_TOP;
    vx = 0;
    vy = 0;
    for (int i = 0; i < 4; i++) begin
      case (i)
        EDGE_TOP: begin
          k = yt; s = dy; lo = xl; hi = xr; par = dx;
        end
        EDGE_RIGHT: begin
          k = xr; s = dx; lo = yb; hi = yt; par = dy;
        end
        EDGE_BOTTOM: begin
          k = yb; s = dy; lo = xl; hi = xr; par = dx;
        end
        default: begin
          k = xl; s = dx; lo = yb; hi = yt; par = dy;
        end
      endcase
      ok = edge_hit(k, s, lo, hi, par, t);
      if (ok && t < a.t) begin
        a.t = t;
        a.found = 1;
        a.edge_id = i[1:0];
        case (i)
          EDGE_TOP:    begin vx = -w; vy = 0;  end
          EDGE_RIGHT:  begin vx = 0;  vy = h;  end
          EDGE_BOTTOM: begin vx = w;  vy = 0;  end
          default:     begin vx = 0;  vy = -h; end
        endcase
      end
    end
    a.ex = clamp32(vx);
    a.ey = clamp32(vy);
    return a;
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 40)) - 20) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-posed scenes: moving box heading at the static one
  function automatic query_t random_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      q.scx = $signed(32'($urandom_range(0, 200)) - 100) <<< 16;
      q.scy = $signed(32'($urandom_range(0, 200)) - 100) <<< 16;
      q.sw  = 31'($urandom_range(0, 40 << 16));
      q.sh  = 31'($urandom_range(0, 40 << 16));
      q.mcx = q.scx + ($signed(32'($urandom_range(0, 160)) - 80) <<< 16)
              + 32'($urandom_range(0, 65535));
      q.mcy = q.scy + ($signed(32'($urandom_range(0, 160)) - 80) <<< 16)
              + 32'($urandom_range(0, 65535));
      q.mw  = 31'($urandom_range(0, 20 << 16));
      q.mh  = 31'($urandom_range(0, 20 << 16));
      q.dx  = (q.scx - q.mcx) + $signed(32'($urandom_range(0, 1 << 20)) - (1 << 19));
      q.dy  = (q.scy - q.mcy) + $signed(32'($urandom_range(0, 1 << 20)) - (1 << 19));
      if ($urandom_range(0, 7) == 0) q.dx = 0;
      if ($urandom_range(0, 7) == 0) q.dy = 0;
      q.limit = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 3 << 16));
    end else begin
      q.scx = rnd32(); q.scy = rnd32();
      q.sw = 31'(rnd32()); q.sh = 31'(rnd32());
      q.mcx = rnd32(); q.mcy = rnd32();
      q.mw = 31'(rnd32()); q.mh = 31'(rnd32());
      q.dx = rnd32(); q.dy = rnd32();
      q.limit = 31'(rnd32());
    end
    return q;
  endfunction

  function automatic query_t make_q(input logic signed [31:0] scx, scy,
                                    input logic [30:0] sw, sh,
                                    input logic signed [31:0] mcx, mcy,
                                    input logic [30:0] mw, mh,
                                    input logic signed [31:0] dx, dy,
                                    input logic [30:0] limit);
    query_t q;
    q.scx = scx; q.scy = scy; q.sw = sw; q.sh = sh;
    q.mcx = mcx; q.mcy = mcy; q.mw = mw; q.mh = mh;
    q.dx = dx; q.dy = dy; q.limit = limit;
    return q;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // stimulus
  initial begin
    localparam logic [31:0] ONE = 32'h10000;
    localparam logic [31:0] SMAX = 32'h7FFFFFFF;
    localparam logic [31:0] SMIN = 32'h80000000;
    localparam logic [30:0] UMAX = 31'h7FFFFFFF;
    rst = 1;
    hold_off = 0;
    stim_done = 0;
    // approach from each side, one edge each
    pending_q.push_back(make_q(0, 0, 2*ONE, 2*ONE, 0, 10*ONE, 0, 0, 0, -ONE*20, 4*ONE));
    pending_q.push_back(make_q(0, 0, 2*ONE, 2*ONE, 10*ONE, 0, 0, 0, -ONE*20, 0, 4*ONE));
    pending_q.push_back(make_q(0, 0, 2*ONE, 2*ONE, 0, -10*ONE, 0, 0, 0, ONE*20, 4*ONE));
    pending_q.push_back(make_q(0, 0, 2*ONE, 2*ONE, -10*ONE, 0, 0, 0, ONE*20, 0, 4*ONE));
    // corner exactly (endpoint of edge parameter), tie top/right
    pending_q.push_back(make_q(0, 0, 2*ONE, 2*ONE, 3*ONE, 3*ONE, 0, 0, -ONE, -ONE, UMAX));
    // ray starts on the edge
    pending_q.push_back(make_q(0, 0, 2*ONE, 2*ONE, 0, ONE, 0, 0, 0, -ONE, ONE));
    // zero step, zero size, zero limit
    pending_q.push_back(make_q(0, 0, 2*ONE, 2*ONE, 0, 5*ONE, 0, 0, 0, 0, UMAX));
    pending_q.push_back(make_q(0, 0, 0, 0, 0, 5*ONE, 0, 0, 0, -ONE, UMAX));
    pending_q.push_back(make_q(0, 0, 2*ONE, 2*ONE, 0, 5*ONE, 0, 0, 0, -ONE, 0));
    // huge time saturates; tiny step
    pending_q.push_back(make_q(SMAX, SMAX, 2, 2, SMIN, SMIN, 0, 0, 1, 1, UMAX));
    pending_q.push_back(make_q(0, 0, 2*ONE, 2*ONE, 0, SMAX, 0, 0, 0, -1, UMAX));
    // edge vector saturation and extremes everywhere
    pending_q.push_back(make_q(0, 0, UMAX, UMAX, 0, 0, UMAX, UMAX, SMAX, SMIN, UMAX));
    pending_q.push_back(make_q(SMIN, SMAX, UMAX, UMAX, SMAX, SMIN, UMAX, UMAX,
                               SMIN, SMAX, UMAX));
    pending_q.push_back(make_q(SMAX, SMIN, 0, UMAX, SMIN, SMAX, UMAX, 0, SMIN, SMIN, UMAX));
    pending_q.push_back(make_q(-1, -1, UMAX, 0, -1, -1, 0, UMAX, SMAX, SMAX, 31'h1));
    // moving away: no hit
    pending_q.push_back(make_q(0, 0, 2*ONE, 2*ONE, 0, 10*ONE, 0, 0, 0, ONE, UMAX));
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;
    for (int i = 0; i < 940; i++) begin
      pending_q.push_back(random_query());
      // one pause until every expected result has come
      if (i == 400) begin
        wait (pending_q.size() == 0 && awaited_q.size() == 0);
        hold_off = 1;
        repeat (20) @(posedge clk);
        hold_off = 0;
      end
    end
    wait (pending_q.size() == 0 && !query.valid);
    wait (awaited_q.size() == 0);
    repeat (30) @(posedge clk);
    stim_done = 1;
  end

  // handshake seen at the rising edge, for the driver
  always @(posedge clk) begin
    in_fire <= query.valid && query.ready;
  end

  // driver: bursts of beats with random gaps, changes at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      query.valid <= 0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (query.valid && !in_fire) begin
      // hold the beat
    end else begin
      if (gap_left > 0 || hold_off || pending_q.size() == 0) begin
        query.valid <= 0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        query_t q;
        q = pending_q.pop_front();
        query.valid <= 1;
        query.stationary_center_x <= q.scx;
        query.stationary_center_y <= q.scy;
        query.stationary_width    <= q.sw;
        query.stationary_height   <= q.sh;
        query.moving_center_x     <= q.mcx;
        query.moving_center_y     <= q.mcy;
        query.moving_width        <= q.mw;
        query.moving_height       <= q.mh;
        query.step_x              <= q.dx;
        query.step_y              <= q.dy;
        query.time_limit          <= q.limit;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: stall pattern of its own, long free-running stretches in between
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[8:7] == 2'b11) result.ready <= 1;
      else result.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 11 != 3);
    end
  end

  // input monitor feeds the predictor, output monitor checks
  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      if (query.valid && query.ready) begin
        query_t q;
        q = make_q(query.stationary_center_x, query.stationary_center_y,
                   query.stationary_width, query.stationary_height,
                   query.moving_center_x, query.moving_center_y,
                   query.moving_width, query.moving_height,
                   query.step_x, query.step_y, query.time_limit);
        awaited_q.push_back(predict_hit(q));
      end
      if (result.valid && result.ready) begin
        answer_t e;
        if (awaited_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result beat at cycle %0d", cycles);
        end else begin
          e = awaited_q.pop_front();
          if (result.hit_time !== e.t || result.hit_found !== e.found ||
              result.hit_edge !== e.edge_id || result.hit_edge_x !== e.ex ||
              result.hit_edge_y !== e.ey) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp t=%h f=%b e=%0d v=(%h,%h) got t=%h f=%b e=%0d v=(%h,%h)",
                       e.t, e.found, e.edge_id, e.ex, e.ey, result.hit_time,
                       result.hit_found, result.hit_edge, result.hit_edge_x,
                       result.hit_edge_y);
          end
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    fork
      wait (stim_done);
      wait (cycles >= LIMIT_CYCLES);
    join_any
    if (!stim_done) begin
      $display("Testbench completed WITH ERRORS");
    end else if (mismatches == 0 && awaited_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
